>>> design/ansi_escape_terminal_parser_unit_defines.svh
// assertion macros shared by the escape parser modules
`ifndef ANSI_ESCAPE_TERMINAL_PARSER_UNIT_DEFINES_SVH
`define ANSI_ESCAPE_TERMINAL_PARSER_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define AETP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AETP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define AETP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/aetp_pkg.sv
// types, codes and helpers of the escape sequence parser
`timescale 1ns / 1ps
package aetp_pkg;

  localparam int ROW_W = 12;
  localparam int COL_W = 8;
  localparam int PARAM_W = 16;

  typedef logic [4:0] cls_t;

  localparam cls_t CLS_OTHER  = 5'd0;
  localparam cls_t CLS_ESC    = 5'd1;
  localparam cls_t CLS_CR     = 5'd2;
  localparam cls_t CLS_LF     = 5'd3;
  localparam cls_t CLS_BS     = 5'd4;
  localparam cls_t CLS_TAB    = 5'd5;
  localparam cls_t CLS_DIGIT  = 5'd6;
  localparam cls_t CLS_SEMI   = 5'd7;
  localparam cls_t CLS_SGR    = 5'd8;
  localparam cls_t CLS_LBRACK = 5'd9;
  localparam cls_t CLS_LPAREN = 5'd10;
  localparam cls_t CLS_ERASE  = 5'd11;
  localparam cls_t CLS_CLEAR  = 5'd12;
  localparam cls_t CLS_UP     = 5'd13;
  localparam cls_t CLS_DOWN   = 5'd14;
  localparam cls_t CLS_RIGHT  = 5'd15;
  localparam cls_t CLS_LEFT   = 5'd16;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_ERASE = 2'd3;

  localparam logic [1:0] REG_DEFAULT_FG = 2'd0;
  localparam logic [1:0] REG_DEFAULT_BG = 2'd1;
  localparam logic [1:0] REG_DEFAULT_UL = 2'd2;

  localparam logic [2:0] RESET_FG = 3'd7;
  localparam logic [2:0] RESET_BG = 3'd0;
  localparam logic       RESET_UL = 1'b0;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_column;
    logic [7:0]       cell_char;
    logic [2:0]       cell_foreground;
    logic [2:0]       cell_background;
    logic             cell_underline;
    logic [ROW_W-1:0] new_cursor_row;
    logic [COL_W-1:0] new_cursor_column;
  } res_t;

  function automatic logic [2:0] digit_color(input logic [3:0] d);
    logic [2:0] c;
    c = (d >= 4'd1 && d <= 4'd7) ? d[2:0] : 3'd0;
    return c;
  endfunction

endpackage

>>> design/ansi_escape_terminal_parser_unit.sv
// a pushed byte is held in the request queue, its result in the result queue
// throughput: one byte per cycle unless the result queue is full, set by the parser
// a two-entry request queue and a two-entry result queue decouple the sides
// reset: queues empty, text mode, cursor at row 0 column 0, parameter zero,
// default registers and current attributes at foreground 7, background 0, no underline
`timescale 1ns / 1ps
module ansi_escape_terminal_parser_unit #(
  parameter int ROWS = 4096,
  parameter int COLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  command,
  output logic [11:0] target_row,
  output logic [7:0]  target_column,
  output logic [7:0]  cell_char,
  output logic [2:0]  cell_foreground,
  output logic [2:0]  cell_background,
  output logic        cell_underline,
  output logic [11:0] new_cursor_row,
  output logic [7:0]  new_cursor_column
);

  import aetp_pkg::*;

  req_t req;
  logic req_empty;
  logic req_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  aetp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .req_pop   (req_pop),
    .req       (req),
    .req_empty (req_empty)
  );

  aetp_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  aetp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_in),
    .rd    (pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (empty)
  );

  assign command           = res_out.command;
  assign target_row        = res_out.target_row;
  assign target_column     = res_out.target_column;
  assign cell_char         = res_out.cell_char;
  assign cell_foreground   = res_out.cell_foreground;
  assign cell_background   = res_out.cell_background;
  assign cell_underline    = res_out.cell_underline;
  assign new_cursor_row    = res_out.new_cursor_row;
  assign new_cursor_column = res_out.new_cursor_column;

endmodule

>>> design/aetp_fifo.sv
// two-entry first-word-fall-through queue
`timescale 1ns / 1ps
`include "ansi_escape_terminal_parser_unit_defines.svh"
module aetp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             wr_ok;
  logic             rd_ok;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr_ok = wr && !full;
  assign rd_ok = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_ok) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (rd_ok) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (wr_ok && !rd_ok) begin
        count <= count + CW'(1);
      end else if (rd_ok && !wr_ok) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wptr] <= wdata;
    end
  end

  `AETP_ASSERT_NEVER(a_count_bound, count > CW'(DEPTH), "queue count above depth")
  `AETP_ASSERT_NEXT(a_count_up, wr_ok && !rd_ok, count == $past(count) + CW'(1), "count did not rise")
  `AETP_ASSERT_NEXT(a_count_down, rd_ok && !wr_ok, count == $past(count) - CW'(1), "count did not fall")

endmodule

>>> design/aetp_front.sv
// byte classifier and request queue in front of the parser
`timescale 1ns / 1ps
module aetp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          full,
  input  logic          req_pop,
  output aetp_pkg::req_t req,
  output logic          req_empty
);

  import aetp_pkg::*;

  req_t in_req;

  always_comb begin
    in_req.data = rx_byte;
    priority if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
      in_req.cls = CLS_DIGIT;
    end else if (rx_byte == CH_ESC) begin
      in_req.cls = CLS_ESC;
    end else if (rx_byte == CH_CR) begin
      in_req.cls = CLS_CR;
    end else if (rx_byte == CH_LF) begin
      in_req.cls = CLS_LF;
    end else if (rx_byte == CH_BS) begin
      in_req.cls = CLS_BS;
    end else if (rx_byte == CH_TAB) begin
      in_req.cls = CLS_TAB;
    end else if (rx_byte == CH_SEMI) begin
      in_req.cls = CLS_SEMI;
    end else if (rx_byte == CH_M) begin
      in_req.cls = CLS_SGR;
    end else if (rx_byte == CH_LBRACK) begin
      in_req.cls = CLS_LBRACK;
    end else if (rx_byte == CH_LPAREN) begin
      in_req.cls = CLS_LPAREN;
    end else if (rx_byte == CH_J) begin
      in_req.cls = CLS_ERASE;
    end else if (rx_byte == CH_K) begin
      in_req.cls = CLS_CLEAR;
    end else if (rx_byte == CH_A) begin
      in_req.cls = CLS_UP;
    end else if (rx_byte == CH_B) begin
      in_req.cls = CLS_DOWN;
    end else if (rx_byte == CH_C) begin
      in_req.cls = CLS_RIGHT;
    end else if (rx_byte == CH_D) begin
      in_req.cls = CLS_LEFT;
    end else begin
      in_req.cls = CLS_OTHER;
    end
  end

  aetp_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(2)
  ) u_req_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (in_req),
    .rd    (req_pop),
    .rdata (req),
    .full  (full),
    .empty (req_empty)
  );

endmodule

>>> design/aetp_back.sv
// parser state machine, cursor, attributes and default registers
`timescale 1ns / 1ps
`include "ansi_escape_terminal_parser_unit_defines.svh"
module aetp_back #(
  parameter int ROWS = 4096,
  parameter int COLS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [2:0]     cfg_data,
  input  aetp_pkg::req_t req,
  input  logic           req_empty,
  output logic           req_pop,
  input  logic           res_full,
  output logic           res_push,
  output aetp_pkg::res_t res
);

  import aetp_pkg::*;

  localparam logic [1:0] MODE_TEXT      = 2'd0;
  localparam logic [1:0] MODE_ESCAPE    = 2'd1;
  localparam logic [1:0] MODE_FORMAT    = 2'd2;
  localparam logic [1:0] MODE_RESETFONT = 2'd3;

  localparam logic [ROW_W-1:0] ROW_LAST = (ROWS > 4096) ? 12'd4095 : ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = (COLS > 256) ? 8'd255 : COL_W'(COLS - 1);

  logic [2:0]         default_fg;
  logic [2:0]         default_bg;
  logic               default_ul;
  logic [1:0]         mode, mode_next;
  logic [PARAM_W-1:0] param, param_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [2:0]         fg, fg_next;
  logic [2:0]         bg, bg_next;
  logic               ul, ul_next;

  logic               go;
  logic [PARAM_W-1:0] n;
  logic [19:0]        acc;
  logic [PARAM_W-1:0] acc_sat;
  logic [16:0]        row_sum;
  logic [16:0]        col_sum;
  logic [ROW_W-1:0]   row_add, row_sub, row_inc;
  logic [COL_W-1:0]   col_add, col_sub, col_inc, col_dec;
  logic [2:0]         sgr_fg, sgr_bg;
  logic               sgr_ul;
  logic               cell_stray;

  assign go       = !req_empty && !res_full;
  assign req_pop  = go;
  assign res_push = go;

  // move amount, decimal accumulate and saturating cursor moves
  assign n       = (param == '0) ? PARAM_W'(1) : param;
  assign acc     = {1'b0, param, 3'b000} + {3'b000, param, 1'b0} + {16'd0, req.data[3:0]};
  assign acc_sat = (acc[19:16] != 4'd0) ? {PARAM_W{1'b1}} : acc[15:0];
  assign row_sum = {5'd0, row} + {1'b0, n};
  assign col_sum = {9'd0, col} + {1'b0, n};
  assign row_add = (row_sum > {5'd0, ROW_LAST}) ? ROW_LAST : row_sum[ROW_W-1:0];
  assign col_add = (col_sum > {9'd0, COL_LAST}) ? COL_LAST : col_sum[COL_W-1:0];
  assign row_sub = (n >= {4'd0, row}) ? '0 : row - n[ROW_W-1:0];
  assign col_sub = (n >= {8'd0, col}) ? '0 : col - n[COL_W-1:0];
  assign row_inc = (row >= ROW_LAST) ? ROW_LAST : row + ROW_W'(1);
  assign col_inc = (col >= COL_LAST) ? COL_LAST : col + COL_W'(1);
  assign col_dec = (col == '0) ? '0 : col - COL_W'(1);

  always_comb begin
    sgr_fg = fg;
    sgr_bg = bg;
    sgr_ul = ul;
    priority if (param == 16'd0) begin
      sgr_fg = default_fg;
      sgr_bg = default_bg;
      sgr_ul = default_ul;
    end else if (param == 16'd4) begin
      sgr_ul = 1'b1;
    end else if (param == 16'd7) begin
      sgr_fg = bg;
      sgr_bg = fg;
    end else if (param >= 16'd30 && param <= 16'd39) begin
      sgr_fg = digit_color(4'(param - 16'd30));
    end else if (param >= 16'd40 && param <= 16'd49) begin
      sgr_bg = digit_color(4'(param - 16'd40));
    end else begin
      // other codes leave the attributes alone
      sgr_fg = fg;
      sgr_bg = bg;
      sgr_ul = ul;
    end
  end

  always_comb begin
    mode_next  = mode;
    param_next = param;
    row_next   = row;
    col_next   = col;
    fg_next    = fg;
    bg_next    = bg;
    ul_next    = ul;
    res.command         = CMD_NONE;
    res.target_row      = row;
    res.target_column   = col;
    res.cell_char       = 8'd0;
    res.cell_foreground = 3'd0;
    res.cell_background = 3'd0;
    res.cell_underline  = 1'b0;
    unique case (mode)
      MODE_TEXT: begin
        unique case (req.cls)
          CLS_ESC: mode_next = MODE_ESCAPE;
          CLS_CR:  col_next = '0;
          CLS_LF:  row_next = row_inc;
          CLS_BS:  col_next = col_dec;
          CLS_TAB: ;
          default: begin
            res.command         = CMD_WRITE;
            res.cell_char       = req.data;
            res.cell_foreground = fg;
            res.cell_background = bg;
            res.cell_underline  = ul;
            col_next            = col_inc;
          end
        endcase
      end
      MODE_ESCAPE: begin
        param_next = '0;
        unique case (req.cls)
          CLS_LBRACK: mode_next = MODE_FORMAT;
          CLS_LPAREN: mode_next = MODE_RESETFONT;
          CLS_ESC:    mode_next = MODE_ESCAPE;
          default:    mode_next = MODE_TEXT;
        endcase
      end
      MODE_FORMAT: begin
        mode_next = MODE_TEXT;
        unique case (req.cls)
          CLS_DIGIT: begin
            param_next = acc_sat;
            mode_next  = MODE_FORMAT;
          end
          CLS_SEMI: begin
            fg_next    = sgr_fg;
            bg_next    = sgr_bg;
            ul_next    = sgr_ul;
            param_next = '0;
            mode_next  = MODE_FORMAT;
          end
          CLS_SGR: begin
            fg_next = sgr_fg;
            bg_next = sgr_bg;
            ul_next = sgr_ul;
          end
          CLS_ERASE: res.command = CMD_ERASE;
          CLS_CLEAR: res.command = CMD_CLEAR;
          CLS_UP:    row_next = row_sub;
          CLS_DOWN:  row_next = row_add;
          CLS_RIGHT: col_next = col_add;
          CLS_LEFT:  col_next = col_sub;
          default:   ;
        endcase
      end
      MODE_RESETFONT: begin
        fg_next   = default_fg;
        bg_next   = default_bg;
        ul_next   = default_ul;
        mode_next = MODE_TEXT;
      end
      default: ;
    endcase
    res.new_cursor_row    = row_next;
    res.new_cursor_column = col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_fg <= RESET_FG;
      default_bg <= RESET_BG;
      default_ul <= RESET_UL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_FG: default_fg <= cfg_data;
        REG_DEFAULT_BG: default_bg <= cfg_data;
        REG_DEFAULT_UL: default_ul <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_TEXT;
      param <= '0;
      row   <= '0;
      col   <= '0;
      fg    <= RESET_FG;
      bg    <= RESET_BG;
      ul    <= RESET_UL;
    end else if (go) begin
      mode  <= mode_next;
      param <= param_next;
      row   <= row_next;
      col   <= col_next;
      fg    <= fg_next;
      bg    <= bg_next;
      ul    <= ul_next;
    end
  end

  // cell fields carry data only on a write
  assign cell_stray = res_push && (res.command != CMD_WRITE) &&
                      ((res.cell_char != 8'd0) || (res.cell_foreground != 3'd0) ||
                       (res.cell_background != 3'd0) || res.cell_underline);

  `AETP_ASSERT_NEVER(a_row_bound, row > ROW_LAST, "cursor row past last row")
  `AETP_ASSERT_NEVER(a_col_bound, col > COL_LAST, "cursor column past last column")
  `AETP_ASSERT_NEVER(a_cell_quiet, cell_stray, "cell fields set without a write")

endmodule
